### sv/deadline_timer_queue_defines.svh
// ---------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Assertion with its own message text.
`define DTQ_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion with the default message text.
`define DTQ_ASSERT(name, prop) \
  `DTQ_ASSERT_MSG(name, prop, "deadline_timer_queue: assertion failed")

`endif

### sv/dtq_pkg.sv
// ---------------------------------------------------------------------------
// Deadline timer queue package
// Field widths, operation and status codes, and the stored slot record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SRC_W  = 8;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned AGE_W  = 32;
  localparam int unsigned STAT_W = 2;

  // Operation codes of an input beat.
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE    = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  // Status codes of a result beat.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RESCHED = 2'd2;

  // One slot of the table as it is kept in memory.
  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [TIME_W-1:0] deadline;
    logic              primary;
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
  } entry_t;

endpackage

### sv/deadline_timer_queue.sv
// ---------------------------------------------------------------------------
// Deadline timer queue
// Bounded table of timed tasks kept in one synchronous memory, scanned one
// slot per cycle for schedule coalescing, source erase and earliest-due fire.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  operation, source_id, deadline,
//                                                is_primary, task_tag, current_time
//   out      output     out_valid_o / out_ready_i fired, fired_source,
//                                                fired_tag, status
//
// Each beat runs in steps: accept, one memory read per slot, a drain step for
// the last read to return, and a write-back step that posts the result. The
// scan over the slot memory's single read port sets the length of a beat.
// Reset clears the valid bits and the insert counter; no clearing pass runs.
// The result sits in an output register, so a new beat is taken while the
// previous result waits; a stalled output holds the write-back step.
`timescale 1ns / 1ps

`include "deadline_timer_queue_defines.svh"

module deadline_timer_queue
  import dtq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [SRC_W-1:0]  source_id_i,
  input  logic [TIME_W-1:0] deadline_i,
  input  logic              is_primary_i,
  input  logic [TAG_W-1:0]  task_tag_i,
  input  logic [TIME_W-1:0] current_time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              fired_o,
  output logic [SRC_W-1:0]  fired_source_o,
  output logic [TAG_W-1:0]  fired_tag_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int unsigned IW      = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST  = IW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  // Latched input beat.
  logic [OP_W-1:0]   op_q;
  logic [SRC_W-1:0]  src_q;
  logic [TIME_W-1:0] dl_q;
  logic              prim_q;
  logic [TAG_W-1:0]  tag_q;
  logic [TIME_W-1:0] now_q;

  // Scan address and the returning compare stage.
  logic [IW-1:0] idx_q;
  logic [IW-1:0] cmp_idx_q;
  logic          cmp_vld_q;

  // Slot memory and valid bits.
  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_data_q;
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  entry_t                 mem_wdata;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [AGE_W-1:0]       insert_counter_q;

  // Scan results.
  logic              match_found_q;
  logic [IW-1:0]     match_idx_q;
  entry_t            match_entry_q;
  logic              free_found_q;
  logic [IW-1:0]     free_idx_q;
  logic              best_found_q;
  logic [IW-1:0]     best_idx_q;
  logic [TIME_W-1:0] best_dl_q;
  logic [AGE_W-1:0]  best_dist_q;
  logic [SRC_W-1:0]  best_src_q;
  logic [TAG_W-1:0]  best_tag_q;

  // Output register.
  logic              out_valid_q;
  logic              fired_q;
  logic [SRC_W-1:0]  fired_src_q;
  logic [TAG_W-1:0]  fired_tag_q;
  logic [STAT_W-1:0] status_q;

  logic             accept;
  logic             commit;
  logic             cur_valid;
  logic             take_match;
  logic             take_free;
  logic             take_best;
  logic             erase_hit;
  logic [AGE_W-1:0] cur_dist;
  logic             is_sched;
  logic             append_commit;
  logic             fire_commit;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign commit     = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign is_sched   = (op_q == OP_SCHEDULE);

  // Compare of the slot that came back from memory this cycle.
  assign cur_valid  = cmp_vld_q && valid_q[cmp_idx_q];
  assign cur_dist   = insert_counter_q - rd_data_q.age;
  assign take_match = cur_valid && is_sched && prim_q && !match_found_q &&
                      rd_data_q.primary && (rd_data_q.source == src_q);
  assign take_free  = cmp_vld_q && !valid_q[cmp_idx_q] && !free_found_q;
  assign erase_hit  = cur_valid && (op_q == OP_ERASE) && (rd_data_q.source == src_q);
  assign take_best  = cur_valid && (op_q == OP_TICK) &&
                      (!best_found_q || (rd_data_q.deadline < best_dl_q) ||
                       ((rd_data_q.deadline == best_dl_q) && (cur_dist > best_dist_q)));

  assign append_commit = commit && is_sched && !match_found_q && free_found_q;
  assign fire_commit   = commit && (op_q == OP_TICK) && best_found_q &&
                         (best_dl_q <= now_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (idx_q == LAST) state_d = S_DRAIN;
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == S_SCAN);
      if (accept) begin
        idx_q <= '0;
      end else if (state_q == S_SCAN && idx_q != LAST) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Input beat latch and compare-stage index; payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      src_q  <= source_id_i;
      dl_q   <= deadline_i;
      prim_q <= is_primary_i;
      tag_q  <= task_tag_i;
      now_q  <= current_time_i;
    end
    cmp_idx_q <= idx_q;
  end

  // Scan result tracking, cleared at each new beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
    end else if (accept) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
    end else begin
      if (take_match) match_found_q <= 1'b1;
      if (take_free)  free_found_q  <= 1'b1;
      if (take_best)  best_found_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_match) begin
      match_idx_q   <= cmp_idx_q;
      match_entry_q <= rd_data_q;
    end
    if (take_free) begin
      free_idx_q <= cmp_idx_q;
    end
    if (take_best) begin
      best_idx_q  <= cmp_idx_q;
      best_dl_q   <= rd_data_q.deadline;
      best_dist_q <= cur_dist;
      best_src_q  <= rd_data_q.source;
      best_tag_q  <= rd_data_q.tag;
    end
  end

  // Write-back: coalesce into the matched primary or append a new slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx_q;
    mem_wdata = '{source: src_q, deadline: dl_q, primary: prim_q,
                  tag: tag_q, age: insert_counter_q};
    if (commit && is_sched) begin
      if (match_found_q) begin
        mem_we         = 1'b1;
        mem_waddr      = match_idx_q;
        mem_wdata      = match_entry_q;
        mem_wdata.tag  = tag_q;
        if (dl_q < match_entry_q.deadline) begin
          mem_wdata.deadline = dl_q;
        end
      end else if (free_found_q) begin
        mem_we = 1'b1;
      end
    end
  end

  // Slot memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[idx_q];
  end

  // Valid bits and the insert counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q          <= '0;
      insert_counter_q <= '0;
    end else begin
      if (erase_hit) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
      if (append_commit) begin
        valid_q[free_idx_q] <= 1'b1;
        insert_counter_q    <= insert_counter_q + 1'b1;
      end
      if (fire_commit) begin
        valid_q[best_idx_q] <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      fired_q     <= fire_commit;
      fired_src_q <= fire_commit ? best_src_q : '0;
      fired_tag_q <= fire_commit ? best_tag_q : '0;
      if (is_sched) begin
        if (match_found_q) begin
          status_q <= ST_RESCHED;
        end else if (free_found_q) begin
          status_q <= ST_OK;
        end else begin
          status_q <= ST_FULL;
        end
      end else begin
        status_q <= ST_OK;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fired_o        = fired_q;
  assign fired_source_o = fired_src_q;
  assign fired_tag_o    = fired_tag_q;
  assign status_o       = status_q;

  // A fired beat always carries an ok status.
  `DTQ_ASSERT(a_fire_status_ok, (out_valid_o && fired_o) |-> (status_o == ST_OK))
  // A beat that fired nothing carries a zero source and tag.
  `DTQ_ASSERT(a_nofire_zero, (out_valid_o && !fired_o) |-> (fired_source_o == '0 && fired_tag_o == '0))
  // The slot that fired is no longer valid afterwards.
  `DTQ_ASSERT(a_fire_clears_slot, fire_commit |=> !valid_q[$past(best_idx_q)])
  // The insert counter moves only on an append.
  `DTQ_ASSERT(a_counter_on_append, (insert_counter_q != $past(insert_counter_q)) |-> $past(append_commit))

endmodule
